### src/fbc_pkg.sv
package fbc_pkg;

  // Store depths and geometry.
  localparam int NUM_PLANES = 6;
  localparam int NUM_POINTS = 8;
  localparam int NUM_AXES   = 3;

  // Fixed field widths of the item.
  localparam int FIELD_W  = 16;
  localparam int OFFSET_W = 40;
  localparam int SLOT_W   = 3;
  localparam int KIND_W   = 2;

  // Item kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_PLANE = 2'd0,
    KIND_LOAD_POINT = 2'd1,
    KIND_TEST       = 2'd2
  } fbc_kind_e;

  // Per-stage load enables of the test pipeline.
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } fbc_ctrl_t;

endpackage

### src/fbc_store.sv
module fbc_store #(
  parameter int COORD_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     wr_plane_i,
  input  logic                                     wr_point_i,
  input  logic        [fbc_pkg::SLOT_W-1:0]        slot_i,
  input  logic signed [fbc_pkg::FIELD_W-1:0]       coef_x_i,
  input  logic signed [fbc_pkg::FIELD_W-1:0]       coef_y_i,
  input  logic signed [fbc_pkg::FIELD_W-1:0]       coef_z_i,
  input  logic signed [fbc_pkg::OFFSET_W-1:0]      plane_offset_i,
  output logic signed [COORD_BITS-1:0]
               norm_o [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES],
  output logic signed [fbc_pkg::OFFSET_W-1:0]      offset_o [fbc_pkg::NUM_PLANES],
  output logic signed [COORD_BITS-1:0]
               point_o [fbc_pkg::NUM_POINTS][fbc_pkg::NUM_AXES]
);

  logic signed [COORD_BITS-1:0] norm_q [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES];
  logic signed [fbc_pkg::OFFSET_W-1:0] offset_q [fbc_pkg::NUM_PLANES];
  logic signed [COORD_BITS-1:0] point_q [fbc_pkg::NUM_POINTS][fbc_pkg::NUM_AXES];
  logic signed [COORD_BITS-1:0] coef_d [fbc_pkg::NUM_AXES];

  // Coefficients are sign-extended or wrapped to the coordinate width.
  assign coef_d[0] = COORD_BITS'(coef_x_i);
  assign coef_d[1] = COORD_BITS'(coef_y_i);
  assign coef_d[2] = COORD_BITS'(coef_z_i);

  // Plane and point slots; both stores clear on reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
        offset_q[p] <= '0;
        for (int a = 0; a < fbc_pkg::NUM_AXES; a++) norm_q[p][a] <= '0;
      end
      for (int c = 0; c < fbc_pkg::NUM_POINTS; c++) begin
        for (int a = 0; a < fbc_pkg::NUM_AXES; a++) point_q[c][a] <= '0;
      end
    end else begin
      if (wr_plane_i) begin
        offset_q[slot_i] <= plane_offset_i;
        for (int a = 0; a < fbc_pkg::NUM_AXES; a++) norm_q[slot_i][a] <= coef_d[a];
      end
      if (wr_point_i) begin
        for (int a = 0; a < fbc_pkg::NUM_AXES; a++) point_q[slot_i][a] <= coef_d[a];
      end
    end
  end

  assign norm_o   = norm_q;
  assign offset_o = offset_q;
  assign point_o  = point_q;

endmodule

### src/fbc_prod.sv
module fbc_prod #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [fbc_pkg::FIELD_W-1:0]  box_min_i [fbc_pkg::NUM_AXES],
  input  logic signed [fbc_pkg::FIELD_W-1:0]  box_max_i [fbc_pkg::NUM_AXES],
  input  logic signed [COORD_BITS-1:0]
               norm_i [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES],
  input  logic signed [fbc_pkg::OFFSET_W-1:0] offset_i [fbc_pkg::NUM_PLANES],
  input  logic signed [COORD_BITS-1:0]
               point_i [fbc_pkg::NUM_POINTS][fbc_pkg::NUM_AXES],
  output logic signed [2*COORD_BITS-1:0]
               prod_lo_o [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES],
  output logic signed [2*COORD_BITS-1:0]
               prod_hi_o [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES],
  output logic signed [fbc_pkg::OFFSET_W-1:0] offset_o [fbc_pkg::NUM_PLANES],
  output logic                                pt_cull_o
);

  localparam int PROD_W = 2 * COORD_BITS;

  logic signed [COORD_BITS-1:0] lo [fbc_pkg::NUM_AXES];
  logic signed [COORD_BITS-1:0] hi [fbc_pkg::NUM_AXES];
  logic signed [PROD_W-1:0] prod_lo_d [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES];
  logic signed [PROD_W-1:0] prod_hi_d [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES];
  logic signed [PROD_W-1:0] prod_lo_q [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES];
  logic signed [PROD_W-1:0] prod_hi_q [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES];
  logic signed [fbc_pkg::OFFSET_W-1:0] offset_q [fbc_pkg::NUM_PLANES];
  logic [fbc_pkg::NUM_AXES-1:0] all_above;
  logic [fbc_pkg::NUM_AXES-1:0] all_below;
  logic pt_cull_d;
  logic pt_cull_q;

  // Box bounds at the coordinate width.
  always_comb begin
    for (int a = 0; a < fbc_pkg::NUM_AXES; a++) begin
      lo[a] = COORD_BITS'(box_min_i[a]);
      hi[a] = COORD_BITS'(box_max_i[a]);
    end
  end

  // One multiplier per plane, axis and bound; the corner that maximizes a
  // plane value is picked later from these partial terms.
  always_comb begin
    for (int p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
      for (int a = 0; a < fbc_pkg::NUM_AXES; a++) begin
        prod_lo_d[p][a] = PROD_W'(norm_i[p][a]) * PROD_W'(lo[a]);
        prod_hi_d[p][a] = PROD_W'(norm_i[p][a]) * PROD_W'(hi[a]);
      end
    end
  end

  // Point test: every frustum point beyond one box face on some axis.
  always_comb begin
    all_above = '1;
    all_below = '1;
    for (int a = 0; a < fbc_pkg::NUM_AXES; a++) begin
      for (int c = 0; c < fbc_pkg::NUM_POINTS; c++) begin
        if (!(point_i[c][a] > hi[a])) all_above[a] = 1'b0;
        if (!(point_i[c][a] < lo[a])) all_below[a] = 1'b0;
      end
    end
    pt_cull_d = |(all_above | all_below);
  end

  // Stage one register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_lo_q <= prod_lo_d;
      prod_hi_q <= prod_hi_d;
      offset_q  <= offset_i;
      pt_cull_q <= pt_cull_d;
    end
  end

  assign prod_lo_o = prod_lo_q;
  assign prod_hi_o = prod_hi_q;
  assign offset_o  = offset_q;
  assign pt_cull_o = pt_cull_q;

endmodule

### src/fbc_sum.sv
module fbc_sum #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk_i,
  input  fbc_pkg::fbc_ctrl_t                  ctrl_i,
  input  logic signed [2*COORD_BITS-1:0]
               prod_lo_i [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES],
  input  logic signed [2*COORD_BITS-1:0]
               prod_hi_i [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES],
  input  logic signed [fbc_pkg::OFFSET_W-1:0] offset_i [fbc_pkg::NUM_PLANES],
  input  logic                                pt_cull_i,
  output logic                                visible_o
);

  localparam int PROD_W = 2 * COORD_BITS;
  localparam int SUM3_W = PROD_W + 2;
  localparam int ACC_W  = ((SUM3_W > fbc_pkg::OFFSET_W) ? SUM3_W : fbc_pkg::OFFSET_W) + 1;

  logic signed [PROD_W-1:0] term_max [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES];
  logic signed [ACC_W-1:0]  sxy_d [fbc_pkg::NUM_PLANES];
  logic signed [ACC_W-1:0]  szo_d [fbc_pkg::NUM_PLANES];
  logic signed [ACC_W-1:0]  sxy_q [fbc_pkg::NUM_PLANES];
  logic signed [ACC_W-1:0]  szo_q [fbc_pkg::NUM_PLANES];
  logic signed [ACC_W-1:0]  total [fbc_pkg::NUM_PLANES];
  logic [fbc_pkg::NUM_PLANES-1:0] behind;
  logic pt_cull_q;
  logic visible_d;
  logic visible_q;

  // Largest term per axis, then two partial sums per plane.
  always_comb begin
    for (int p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
      for (int a = 0; a < fbc_pkg::NUM_AXES; a++) begin
        term_max[p][a] = (prod_hi_i[p][a] > prod_lo_i[p][a]) ? prod_hi_i[p][a]
                                                            : prod_lo_i[p][a];
      end
      sxy_d[p] = ACC_W'(term_max[p][0]) + ACC_W'(term_max[p][1]);
      szo_d[p] = ACC_W'(term_max[p][2]) + ACC_W'(offset_i[p]);
    end
  end

  // Stage two register.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en2) begin
      sxy_q     <= sxy_d;
      szo_q     <= szo_d;
      pt_cull_q <= pt_cull_i;
    end
  end

  // A plane culls when even its best corner is strictly behind it.
  always_comb begin
    for (int p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
      total[p]  = sxy_q[p] + szo_q[p];
      behind[p] = total[p][ACC_W-1];
    end
    visible_d = !(pt_cull_q || (|behind));
  end

  // Stage three is the output register.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en3) begin
      visible_q <= visible_d;
    end
  end

  assign visible_o = visible_q;

endmodule

### src/frustum_box_cull_test.sv
// A test item's result passes the product, partial-sum and output registers in order and
// is presented once the output register holds it; it is taken while out_stall_i is low.
// Throughput: one item per cycle; the three register stages (products, partial sums,
// visibility flag) each take a new item when empty or when the next one moves on.
// Load items update the slot stores at acceptance and give no result.
// Reset clears all plane and point slots to zero and empties the pipeline.
module frustum_box_cull_test #(
  parameter int COORD_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic        [fbc_pkg::KIND_W-1:0]  kind_i,
  input  logic        [fbc_pkg::SLOT_W-1:0]  slot_i,
  input  logic signed [fbc_pkg::FIELD_W-1:0] coef_x_i,
  input  logic signed [fbc_pkg::FIELD_W-1:0] coef_y_i,
  input  logic signed [fbc_pkg::FIELD_W-1:0] coef_z_i,
  input  logic signed [fbc_pkg::OFFSET_W-1:0] plane_offset_i,
  input  logic signed [fbc_pkg::FIELD_W-1:0] box_min_x_i,
  input  logic signed [fbc_pkg::FIELD_W-1:0] box_min_y_i,
  input  logic signed [fbc_pkg::FIELD_W-1:0] box_min_z_i,
  input  logic signed [fbc_pkg::FIELD_W-1:0] box_max_x_i,
  input  logic signed [fbc_pkg::FIELD_W-1:0] box_max_y_i,
  input  logic signed [fbc_pkg::FIELD_W-1:0] box_max_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               visible_o
);

  localparam int PROD_W = 2 * COORD_BITS;

  logic in_accept;
  logic is_test;
  logic wr_plane;
  logic wr_point;
  logic v1_q, v2_q, v3_q;
  logic v1_d, v2_d, v3_d;
  fbc_pkg::fbc_ctrl_t ctrl;

  logic signed [fbc_pkg::FIELD_W-1:0] box_min [fbc_pkg::NUM_AXES];
  logic signed [fbc_pkg::FIELD_W-1:0] box_max [fbc_pkg::NUM_AXES];
  logic signed [COORD_BITS-1:0] norm [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES];
  logic signed [fbc_pkg::OFFSET_W-1:0] offset [fbc_pkg::NUM_PLANES];
  logic signed [COORD_BITS-1:0] point [fbc_pkg::NUM_POINTS][fbc_pkg::NUM_AXES];
  logic signed [PROD_W-1:0] prod_lo [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES];
  logic signed [PROD_W-1:0] prod_hi [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES];
  logic signed [fbc_pkg::OFFSET_W-1:0] offset_s1 [fbc_pkg::NUM_PLANES];
  logic pt_cull_s1;

  // Each stage loads when it is empty or its successor moves on.
  always_comb begin
    ctrl.en3 = !v3_q || !out_stall_i;
    ctrl.en2 = !v2_q || ctrl.en3;
    ctrl.en1 = !v1_q || ctrl.en2;
  end

  assign in_stall_o = !ctrl.en1;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_test    = (kind_i == fbc_pkg::KIND_TEST);
  assign wr_plane   = in_accept && (kind_i == fbc_pkg::KIND_LOAD_PLANE)
                      && (slot_i < fbc_pkg::SLOT_W'(fbc_pkg::NUM_PLANES));
  assign wr_point   = in_accept && (kind_i == fbc_pkg::KIND_LOAD_POINT);

  // Valid bits follow the test items down the pipeline.
  always_comb begin
    v1_d = ctrl.en1 ? (in_accept && is_test) : v1_q;
    v2_d = ctrl.en2 ? v1_q : v2_q;
    v3_d = ctrl.en3 ? v2_q : v3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  assign out_valid_o = v3_q;

  assign box_min[0] = box_min_x_i;
  assign box_min[1] = box_min_y_i;
  assign box_min[2] = box_min_z_i;
  assign box_max[0] = box_max_x_i;
  assign box_max[1] = box_max_y_i;
  assign box_max[2] = box_max_z_i;

  fbc_store #(
    .COORD_BITS(COORD_BITS)
  ) u_store (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_plane_i     (wr_plane),
    .wr_point_i     (wr_point),
    .slot_i         (slot_i),
    .coef_x_i       (coef_x_i),
    .coef_y_i       (coef_y_i),
    .coef_z_i       (coef_z_i),
    .plane_offset_i (plane_offset_i),
    .norm_o         (norm),
    .offset_o       (offset),
    .point_o        (point)
  );

  fbc_prod #(
    .COORD_BITS(COORD_BITS)
  ) u_prod (
    .clk_i     (clk_i),
    .en_i      (ctrl.en1),
    .box_min_i (box_min),
    .box_max_i (box_max),
    .norm_i    (norm),
    .offset_i  (offset),
    .point_i   (point),
    .prod_lo_o (prod_lo),
    .prod_hi_o (prod_hi),
    .offset_o  (offset_s1),
    .pt_cull_o (pt_cull_s1)
  );

  fbc_sum #(
    .COORD_BITS(COORD_BITS)
  ) u_sum (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .prod_lo_i (prod_lo),
    .prod_hi_i (prod_hi),
    .offset_i  (offset_s1),
    .pt_cull_i (pt_cull_s1),
    .visible_o (visible_o)
  );

endmodule
